@@ rtl/aging_priority_table_ttl_defines.svh @@
// Assertion helpers used by the top-level RTL.
`ifndef AGING_PRIORITY_TABLE_TTL_DEFINES_SVH
`define AGING_PRIORITY_TABLE_TTL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define APT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define APT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/apt_pkg.sv @@
package apt_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam logic [23:0] DECAY_RESET = 24'd65536;
   localparam logic [18:0] ELAPSED_MAX = 19'd327680;
   localparam logic [4:0] MAX_OUT = 5'd16;

   typedef enum logic [2:0] {
      CMD_IDLE,
      CMD_ADD,
      CMD_AGE,
      CMD_COMPACT,
      CMD_TAKE
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOSS,
      ST_AGE,
      ST_COMPACT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] id;
      logic [31:0] prio;
      logic [31:0] life;
   } entry_type;

   typedef struct packed {
      logic        valid;
      logic        more;
      logic [15:0] id;
      logic [31:0] prio;
   } cand_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] id;
      logic [31:0] prio;
      logic [31:0] life;
      logic [26:0] loss;
      logic [18:0] elapsed;
   } ctrl_type;

endpackage

@@ rtl/apt_cell.sv @@
module apt_cell #(
   parameter int DEPTH = apt_pkg::DEPTH_DEFAULT,
   parameter int IDX = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  apt_pkg::ctrl_type          ctrl,
   input  logic [$clog2(DEPTH)-1:0]   take_idx,
   input  apt_pkg::entry_type         nb_in,
   output apt_pkg::entry_type         ent_out,
   input  logic                       hole_in,
   output logic                       hole_out,
   input  apt_pkg::cand_type          cand_in,
   input  logic [$clog2(DEPTH)-1:0]   cidx_in,
   output apt_pkg::cand_type          cand_out,
   output logic [$clog2(DEPTH)-1:0]   cidx_out
);
   localparam int IW = $clog2(DEPTH);

   apt_pkg::entry_type ent_ff, ent_in;
   logic taken_ff, taken_in;
   apt_pkg::cand_type cand_ff, cand_in_nx;
   logic [IW-1:0] cidx_ff, cidx_in_nx;

   logic        elig;
   logic        own_wins;
   logic [32:0] pdiff, ldiff;
   logic [31:0] pnew, lnew;

   assign elig = ent_ff.valid & ~taken_ff;
   assign hole_out = hole_in | ~ent_ff.valid;
   assign ent_out = ent_ff;
   assign cand_out = cand_ff;
   assign cidx_out = cidx_ff;

   always_comb begin
      pdiff = {ent_ff.prio[31], ent_ff.prio} - {6'd0, ctrl.loss};
      ldiff = {ent_ff.life[31], ent_ff.life} - {14'd0, ctrl.elapsed};
      // Saturate when the 33-bit difference leaves the 32-bit range.
      if (pdiff[32] != pdiff[31]) begin
         pnew = pdiff[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         pnew = pdiff[31:0];
      end
      if (ldiff[32] != ldiff[31]) begin
         lnew = ldiff[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         lnew = ldiff[31:0];
      end
   end

   always_comb begin
      ent_in = ent_ff;
      taken_in = taken_ff;
      case (ctrl.cmd)
         apt_pkg::CMD_ADD: begin
            if (!ent_ff.valid && !hole_in) begin
               ent_in.valid = 1'b1;
               ent_in.id = ctrl.id;
               ent_in.prio = ctrl.prio;
               ent_in.life = ctrl.life;
            end
         end
         apt_pkg::CMD_AGE: begin
            ent_in.prio = pnew;
            ent_in.life = lnew;
            ent_in.valid = ent_ff.valid && !pnew[31] && (pnew != 32'd0)
                           && !lnew[31] && (lnew != 32'd0);
            taken_in = 1'b0;
         end
         apt_pkg::CMD_COMPACT: begin
            if (hole_out) begin
               ent_in = nb_in;
            end
         end
         apt_pkg::CMD_TAKE: begin
            if (elig && take_idx == IW'(IDX)) begin
               taken_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // The running best moves one cell per cycle; ties keep the earlier cell.
   always_comb begin
      own_wins = elig && (!cand_in.valid || $signed(ent_ff.prio) > $signed(cand_in.prio));
      cand_in_nx.valid = cand_in.valid | elig;
      cand_in_nx.more = cand_in.more | (cand_in.valid & elig);
      if (own_wins) begin
         cand_in_nx.id = ent_ff.id;
         cand_in_nx.prio = ent_ff.prio;
         cidx_in_nx = IW'(IDX);
      end else begin
         cand_in_nx.id = cand_in.id;
         cand_in_nx.prio = cand_in.prio;
         cidx_in_nx = cidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
         taken_ff <= 1'b0;
         cand_ff.valid <= 1'b0;
         cand_ff.more <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
         taken_ff <= taken_in;
         cand_ff.valid <= cand_in_nx.valid;
         cand_ff.more <= cand_in_nx.more;
      end
      ent_ff.id <= ent_in.id;
      ent_ff.prio <= ent_in.prio;
      ent_ff.life <= ent_in.life;
      cand_ff.id <= cand_in_nx.id;
      cand_ff.prio <= cand_in_nx.prio;
      cidx_ff <= cidx_in_nx;
   end

endmodule

@@ rtl/aging_priority_table_ttl.sv @@
// Add: the result is registered in the cycle after accept; the next beat is taken in the same cycle it drains.
// Query: a loss step and an aging step, then compaction, then per result a scan and an emit step
// while the running maximum ripples down the row of cells; one query at a time.
// Reset is synchronous and active high: table empty, decay_rate 1.0, no result pending.
`include "aging_priority_table_ttl_defines.svh"

module aging_priority_table_ttl #(
   parameter int DEPTH = apt_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [15:0] req_item_id,
   input  logic signed [31:0] req_start_priority,
   input  logic signed [31:0] req_lifetime,
   input  logic signed [31:0] req_elapsed,
   input  logic [4:0]  req_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_result_id,
   output logic        rsp_found,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [23:0] csr_wdata
);
   localparam int IW = $clog2(DEPTH);

   apt_pkg::state_type state_ff, state_in;
   logic [23:0] decay_ff;
   logic [18:0] el_ff, el_in;
   logic [26:0] loss_ff, loss_in;
   logic [4:0]  want_ff, want_in;
   logic [4:0]  k_ff, k_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic        rsp_found_ff, rsp_found_in, rsp_last_ff, rsp_last_in;

   apt_pkg::ctrl_type ctrl;
   apt_pkg::entry_type ent [DEPTH];
   apt_pkg::entry_type nb [DEPTH];
   logic hole [DEPTH+1];
   apt_pkg::cand_type cand [DEPTH+1];
   logic [IW-1:0] cidx [DEPTH+1];

   logic out_free, full, empty, fin;
   logic [42:0] prod;

   assign hole[0] = 1'b0;
   assign cand[0] = '0;
   assign cidx[0] = '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == DEPTH - 1) begin : g_tail
         assign nb[g] = '0;
      end else begin : g_mid
         assign nb[g] = ent[g+1];
      end
      apt_cell #(.DEPTH(DEPTH), .IDX(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .take_idx (cidx[DEPTH]),
         .nb_in    (nb[g]),
         .ent_out  (ent[g]),
         .hole_in  (hole[g]),
         .hole_out (hole[g+1]),
         .cand_in  (cand[g]),
         .cidx_in  (cidx[g]),
         .cand_out (cand[g+1]),
         .cidx_out (cidx[g+1])
      );
   end

   assign full = ~hole[DEPTH];
   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign empty = (want_ff == 5'd0) | ~cand[DEPTH].valid;
   assign fin = empty | (k_ff + 5'd1 == want_ff) | ~cand[DEPTH].more;
   assign prod = 43'(decay_ff) * 43'(el_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_last = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      el_in = el_ff;
      loss_in = loss_ff;
      want_in = want_ff;
      k_in = k_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_id_in = rsp_id_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in = rsp_last_ff;
      req_ready = 1'b0;
      ctrl.cmd = apt_pkg::CMD_IDLE;
      ctrl.id = req_item_id;
      ctrl.prio = req_start_priority;
      ctrl.life = req_lifetime;
      ctrl.loss = loss_ff;
      ctrl.elapsed = el_ff;
      case (state_ff)
         apt_pkg::ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               if (!req_mode) begin
                  ctrl.cmd = apt_pkg::CMD_ADD;
                  rsp_valid_in = 1'b1;
                  rsp_id_in = full ? 16'd0 : req_item_id;
                  rsp_found_in = ~full;
                  rsp_last_in = 1'b1;
               end else begin
                  if (req_elapsed[31]) begin
                     el_in = '0;
                  end else if (req_elapsed > $signed({13'd0, apt_pkg::ELAPSED_MAX})) begin
                     el_in = apt_pkg::ELAPSED_MAX;
                  end else begin
                     el_in = req_elapsed[18:0];
                  end
                  want_in = (req_count > apt_pkg::MAX_OUT) ? apt_pkg::MAX_OUT : req_count;
                  k_in = '0;
                  state_in = apt_pkg::ST_LOSS;
               end
            end
         end
         apt_pkg::ST_LOSS: begin
            loss_in = prod[42:16];
            state_in = apt_pkg::ST_AGE;
         end
         apt_pkg::ST_AGE: begin
            ctrl.cmd = apt_pkg::CMD_AGE;
            cnt_in = '0;
            state_in = apt_pkg::ST_COMPACT;
         end
         apt_pkg::ST_COMPACT: begin
            ctrl.cmd = apt_pkg::CMD_COMPACT;
            cnt_in = cnt_ff + IW'(1);
            if (cnt_ff == IW'(DEPTH - 1)) begin
               cnt_in = '0;
               state_in = apt_pkg::ST_SCAN;
            end
         end
         apt_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + IW'(1);
            if (cnt_ff == IW'(DEPTH - 1)) begin
               cnt_in = '0;
               state_in = apt_pkg::ST_EMIT;
            end
         end
         apt_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in = empty ? 16'd0 : cand[DEPTH].id;
               rsp_found_in = ~empty;
               rsp_last_in = fin;
               if (!empty) begin
                  ctrl.cmd = apt_pkg::CMD_TAKE;
               end
               k_in = k_ff + 5'd1;
               state_in = fin ? apt_pkg::ST_IDLE : apt_pkg::ST_SCAN;
            end
         end
         default: begin
            state_in = apt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         decay_ff <= apt_pkg::DECAY_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            decay_ff <= csr_wdata;
         end
      end
      el_ff <= el_in;
      loss_ff <= loss_in;
      want_ff <= want_in;
      k_ff <= k_in;
      cnt_ff <= cnt_in;
      rsp_id_ff <= rsp_id_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff <= rsp_last_in;
   end

   `APT_ASSERT_NEXT(a_query_starts, clock, reset, req_valid && req_ready && req_mode, state_ff == apt_pkg::ST_LOSS, "query did not start aging")
   `APT_ASSERT_NEXT(a_last_idle, clock, reset, state_ff == apt_pkg::ST_EMIT && out_free && fin, state_ff == apt_pkg::ST_IDLE && rsp_valid_ff && rsp_last_ff, "final result did not end the query")
   `APT_ASSERT_NEXT(a_more_scan, clock, reset, state_ff == apt_pkg::ST_EMIT && out_free && !fin, state_ff == apt_pkg::ST_SCAN && !rsp_last_ff && rsp_found_ff, "middle result did not rescan")
   `APT_ASSERT_NOW(a_busy_no_req, clock, reset, state_ff != apt_pkg::ST_IDLE, !req_ready, "request taken while a query is running")

endmodule

@@ verif/aging_priority_table_ttl_tb.sv @@
`timescale 1ns / 1ps

module aging_priority_table_ttl_tb;

   localparam int TBL_DEPTH = 16;
   localparam int RANDOM_ITEMS = 140;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct {
      logic        mode;
      logic [15:0] id;
      logic [31:0] prio;
      logic [31:0] life;
      logic [31:0] elapsed;
      logic [4:0]  count;
      bit          typed;
      logic [15:0] want_id;
      logic        want_found;
   } beat_type;

   typedef struct packed {
      logic [15:0] id;
      logic        found;
      logic        last;
   } rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = 1'b0;
   logic [15:0] req_item_id = '0;
   logic signed [31:0] req_start_priority = '0;
   logic signed [31:0] req_lifetime = '0;
   logic signed [31:0] req_elapsed = '0;
   logic [4:0] req_count = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_result_id;
   logic rsp_found;
   logic rsp_last;
   logic csr_we = 1'b0;
   logic [23:0] csr_wdata = '0;

   // Predictor state.
   logic [15:0] tbl_id [TBL_DEPTH];
   logic signed [31:0] tbl_prio [TBL_DEPTH];
   logic signed [31:0] tbl_life [TBL_DEPTH];
   int tbl_count;
   logic [23:0] decay_rate;

   rsp_type pending_rsp [$];
   beat_type send_q [$];
   int fail_count = 0;
   longint cycle_count = 0;
   bit long_stall_req = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   aging_priority_table_ttl DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_item_id(req_item_id), .req_start_priority(req_start_priority),
      .req_lifetime(req_lifetime), .req_elapsed(req_elapsed), .req_count(req_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result_id(rsp_result_id),
      .rsp_found(rsp_found), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   function automatic logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Adds an entry, or ages, compacts and ranks the table; queues the expected beats.
   task automatic predict_beat(input beat_type b);
      longint el;
      longint loss;
      int w;
      int n;
      int best;
      bit taken [TBL_DEPTH];
      rsp_type r;
      if (b.mode == MODE_ADD) begin
         if (tbl_count < TBL_DEPTH) begin
            tbl_id[tbl_count] = b.id;
            tbl_prio[tbl_count] = b.prio;
            tbl_life[tbl_count] = b.life;
            tbl_count++;
            r = '{id: b.id, found: 1'b1, last: 1'b1};
         end else begin
            r = '{id: 16'd0, found: 1'b0, last: 1'b1};
         end
         pending_rsp.push_back(r);
         return;
      end
      el = longint'($signed(b.elapsed));
      if (el < 0) el = 0;
      if (el > 327680) el = 327680;
      loss = (longint'(decay_rate) * el) >>> 16;
      w = 0;
      for (int i = 0; i < tbl_count; i++) begin
         logic signed [31:0] p;
         logic signed [31:0] l;
         p = sat32(longint'(tbl_prio[i]) - loss);
         l = sat32(longint'(tbl_life[i]) - el);
         if (p > 0 && l > 0) begin
            tbl_id[w] = tbl_id[i];
            tbl_prio[w] = p;
            tbl_life[w] = l;
            w++;
         end
      end
      tbl_count = w;
      n = b.count;
      if (n > tbl_count) n = tbl_count;
      if (n == 0) begin
         pending_rsp.push_back('{id: 16'd0, found: 1'b0, last: 1'b1});
         return;
      end
      foreach (taken[i]) taken[i] = 1'b0;
      for (int k = 0; k < n; k++) begin
         best = -1;
         for (int i = 0; i < tbl_count; i++)
            if (!taken[i] && (best < 0 || tbl_prio[i] > tbl_prio[best])) best = i;
         taken[best] = 1'b1;
         pending_rsp.push_back('{id: tbl_id[best], found: 1'b1, last: (k + 1 == n)});
      end
   endtask

   // Request driver: the head of the send queue is held until it is taken.
   always @(negedge clock) begin
      if (send_q.size() != 0) begin
         req_valid <= 1'b1;
         req_mode <= send_q[0].mode;
         req_item_id <= send_q[0].id;
         req_start_priority <= send_q[0].prio;
         req_lifetime <= send_q[0].life;
         req_elapsed <= send_q[0].elapsed;
         req_count <= send_q[0].count;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Request monitor: an accepted beat leaves the queue and updates the predictor.
   always @(posedge clock) begin
      beat_type a;
      if (!reset && req_valid && req_ready) begin
         a = send_q.pop_front();
         predict_beat(a);
         if (a.typed) begin
            void'(pending_rsp.pop_back());
            pending_rsp.push_back('{id: a.want_id, found: a.want_found, last: 1'b1});
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected beat id=%h found=%b last=%b", $time,
                     rsp_result_id, rsp_found, rsp_last);
            fail_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_result_id !== e.id || rsp_found !== e.found || rsp_last !== e.last) begin
               $display("%0t: expected id=%h found=%b last=%b, actual id=%h found=%b last=%b",
                        $time, e.id, e.found, e.last, rsp_result_id, rsp_found, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // Receiver: its own stall pattern, plus one long hold-off on request.
   initial begin
      int hold;
      @(negedge clock);
      forever begin
         if (long_stall_req) begin
            rsp_ready <= 1'b0;
            hold = 400;
            while (hold > 0) begin
               @(negedge clock);
               hold--;
            end
            long_stall_req = 1'b0;
         end
         rsp_ready <= (cycle_count % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_beat(input beat_type b);
      send_q.push_back(b);
      while (send_q.size() != 0) @(negedge clock);
   endtask

   task automatic drain_table();
      while (pending_rsp.size() != 0) @(negedge clock);
      // Leave a quiet stretch before the next register write.
      repeat (2 + TBL_DEPTH + 17 * (TBL_DEPTH + 1)) @(negedge clock);
   endtask

   task automatic write_decay(input logic [23:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      decay_rate = v;
   endtask

   function automatic beat_type add_beat(logic [15:0] id, logic [31:0] p, logic [31:0] l);
      beat_type b;
      b = '{mode: MODE_ADD, id: id, prio: p, life: l, elapsed: $urandom,
            count: 5'($urandom), typed: 1'b0, want_id: 16'd0, want_found: 1'b0};
      return b;
   endfunction

   function automatic beat_type query_beat(logic [31:0] el, logic [4:0] c);
      beat_type b;
      b = '{mode: MODE_QUERY, id: 16'($urandom), prio: $urandom, life: $urandom,
            elapsed: el, count: c, typed: 1'b0, want_id: 16'd0, want_found: 1'b0};
      return b;
   endfunction

   function automatic beat_type random_beat();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60)
         return add_beat(16'($urandom),
                         (sel < 5) ? $urandom : $urandom_range(1, 32'h00ff_ffff),
                         (sel < 8) ? $urandom : $urandom_range(1, 32'h0010_0000));
      return query_beat((sel < 70) ? $urandom : $urandom_range(0, 65536),
                        5'($urandom_range(0, 16 + (sel & 15))));
   endfunction

   beat_type dir_beats [$];
   beat_type b;

   initial begin
      int gap;
      int burst;
      foreach (tbl_id[i]) begin
         tbl_id[i] = '0;
         tbl_prio[i] = '0;
         tbl_life[i] = '0;
      end
      tbl_count = 0;
      decay_rate = apt_pkg::DECAY_RESET;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty table query, field extremes, full table, drops, ties.
      b = query_beat(32'h7fffffff, 5'd16);
      b.typed = 1'b1; b.want_id = 16'd0; b.want_found = 1'b0;
      dir_beats.push_back(b);
      b = add_beat(16'hffff, 32'h7fffffff, 32'h7fffffff);
      b.typed = 1'b1; b.want_id = 16'hffff; b.want_found = 1'b1;
      dir_beats.push_back(b);
      b = add_beat(16'h0000, 32'h80000000, 32'h80000000);
      b.typed = 1'b1; b.want_id = 16'h0000; b.want_found = 1'b1;
      dir_beats.push_back(b);
      dir_beats.push_back(add_beat(16'h1234, 32'h00010000, 32'h00050000));
      dir_beats.push_back(add_beat(16'h5678, 32'h00010000, 32'h00050001));
      dir_beats.push_back(add_beat(16'h9abc, 32'h00000000, 32'h00100000));
      dir_beats.push_back(query_beat(32'h80000000, 5'd0));
      dir_beats.push_back(query_beat(32'h00000000, 5'd31));
      for (int i = 0; i < 13; i++)
         dir_beats.push_back(add_beat(16'h0100 + i[15:0], 32'h00020000 + i, 32'h00080000));
      b = add_beat(16'haaaa, 32'h1, 32'h1);
      b.typed = 1'b1; b.want_id = 16'd0; b.want_found = 1'b0;
      dir_beats.push_back(b);
      dir_beats.push_back(query_beat(32'h00010000, 5'd1));
      dir_beats.push_back(query_beat(32'h00050000, 5'd16));
      foreach (dir_beats[i]) send_beat(dir_beats[i]);
      drain_table();

      // Random phases across decay settings, extremes included.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_decay(24'd0);
            1: write_decay(24'hffffff);
            2: write_decay(24'd65536);
            default: write_decay(24'($urandom_range(0, 24'h03ffff)));
         endcase
         for (int n = 0; n < RANDOM_ITEMS / 5; ) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n < RANDOM_ITEMS / 5) begin
               send_beat(random_beat());
               burst--;
               n++;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
            repeat (gap) @(negedge clock);
         end
         if (ph == 2) begin
            // Sender waits for every outstanding beat before resuming.
            while (pending_rsp.size() != 0) @(negedge clock);
            long_stall_req = 1'b1;
            for (int i = 0; i < 6; i++)
               send_beat(add_beat(16'($urandom), 32'h00100000, 32'h00100000));
            send_beat(query_beat(32'd0, 5'd16));
         end
         drain_table();
      end

      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
